/* hdl/category_leaky_bucket_limiter_defines.svh */
// Assertion macros shared by the leaky-bucket limiter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CATEGORY_LEAKY_BUCKET_LIMITER_DEFINES_SVH
`define CATEGORY_LEAKY_BUCKET_LIMITER_DEFINES_SVH

`ifndef SYNTH
`define LLB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LLB_ASSERT(lbl, clk, rst_n, prop, msg)
`define LLB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/llb_pkg.sv */
// Shared widths, codes, reset values and types of the leaky-bucket limiter.
// Used by every module of the block; depends on nothing.
package llb_pkg;

    localparam int LVL_W       = 24;
    localparam int TIME_W      = 32;
    localparam int DIFF_W      = TIME_W - 1;
    localparam int OP_W        = 2;
    localparam int CAT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_BUCKETS = 2;
    localparam int RC6_W       = LVL_W + 3;
    localparam int DLO_W       = 16;
    localparam int DHI_W       = DIFF_W - DLO_W;
    localparam int PLO_W       = RC6_W + DLO_W;
    localparam int PHI_W       = RC6_W + DHI_W;
    localparam int PROD_W      = RC6_W + DIFF_W;
    localparam int COST_PROD_W = 2 * LVL_W;
    localparam int COST_W      = COST_PROD_W - 16;
    localparam int SUM_W       = COST_W + 1;
    localparam int Y_SHIFT     = 3;
    localparam int Y_W         = 31;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int QP_W        = Y_W + RECIP_W;
    localparam int Q_W         = QP_W - RECIP_SHIFT;

    // Decay of at least 2^24 empties any bucket: product >= 1000 * 2^24.
    localparam logic [PROD_W-1:0]  SAT_PRODUCT = 58'd16777216000;
    // floor(2^32 / 125); the quotient estimate is low by at most one.
    localparam logic [RECIP_W-1:0] RECIP_125   = 26'd34359738;
    localparam logic [Y_W-1:0]     DIV_125     = 31'd125;

    localparam logic [LVL_W-1:0] LVL_MAX        = '1;
    localparam logic [LVL_W-1:0] RATE_LIMIT_RST = 24'd65536;
    localparam logic [LVL_W-1:0] RATE_COST_RST  = 24'd65536;
    localparam logic [LVL_W-1:0] COST_CAT_RST   = 24'd6554;
    localparam logic [RC6_W-1:0] RC6_RST        = 27'd393216;

    localparam logic [OP_W-1:0] OP_DRAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [CAT_W-1:0] CAT_ONE = 2'd1;
    localparam logic [CAT_W-1:0] CAT_TWO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_COST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_CAT_ONE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_CAT_TWO = 2'd3;

    typedef struct packed {
        logic [LVL_W-1:0] rate_limit;
        logic [LVL_W-1:0] rate_cost;
        logic [LVL_W-1:0] cost_one;
        logic [LVL_W-1:0] cost_two;
        logic [RC6_W-1:0] rate_cost_x6;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CAT_W-1:0] cat;
    } item_t;

    function automatic logic is_limited_cat(input logic [CAT_W-1:0] cat);
        return (cat == CAT_ONE) || (cat == CAT_TWO);
    endfunction

    function automatic logic is_request(input item_t it);
        return (it.op == OP_REQUEST) && is_limited_cat(it.cat);
    endfunction

endpackage

/* hdl/llb_cfg.sv */
// Configuration register file of the leaky-bucket limiter.
// Depends on llb_pkg; also keeps rate_cost times six for the drain multiplier.
module llb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [llb_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [llb_pkg::LVL_W-1:0]     cfg_wdata,
    output llb_pkg::cfg_t                 cfg
);
    import llb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RATE_LIMIT: cfg_next.rate_limit = cfg_wdata;
                CFG_RATE_COST: begin
                    cfg_next.rate_cost    = cfg_wdata;
                    cfg_next.rate_cost_x6 = (RC6_W'(cfg_wdata) << 2) + (RC6_W'(cfg_wdata) << 1);
                end
                CFG_COST_CAT_ONE: cfg_next.cost_one = cfg_wdata;
                CFG_COST_CAT_TWO: cfg_next.cost_two = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_limit   <= RATE_LIMIT_RST;
            cfg_reg.rate_cost    <= RATE_COST_RST;
            cfg_reg.cost_one     <= COST_CAT_RST;
            cfg_reg.cost_two     <= COST_CAT_RST;
            cfg_reg.rate_cost_x6 <= RC6_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/llb_front.sv */
// Input register stage: accepts a beat, tracks the stored time and forms the elapsed time.
// Depends on llb_pkg and the assertion macros.
`include "category_leaky_bucket_limiter_defines.svh"

module llb_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [llb_pkg::OP_W-1:0]   in_op,
    input  logic [llb_pkg::TIME_W-1:0] in_time,
    input  logic [llb_pkg::CAT_W-1:0]  in_cat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output llb_pkg::item_t             out_item,
    output logic [llb_pkg::DIFF_W-1:0] out_diff
);
    import llb_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    item_t             item_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0] diff_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    logic [TIME_W-1:0] elapsed;
    logic              accept;
    logic              drains;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        elapsed = in_time - last_time_reg;
        drains  = (in_op == OP_DRAIN) || ((in_op == OP_REQUEST) && is_limited_cat(in_cat));
        // A backwards step only resyncs the time; it passes zero elapsed time on.
        diff_next = (drains && !elapsed[TIME_W-1]) ? elapsed[DIFF_W-1:0] : '0;
        last_time_next = last_time_reg;
        if (accept && (drains || (in_op == OP_CLEAR))) begin
            last_time_next = in_time;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            last_time_reg <= '0;
        end else begin
            valid_reg     <= valid_next;
            last_time_reg <= last_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op  <= in_op;
            item_reg.cat <= in_cat;
            diff_reg     <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_diff  = diff_reg;

    `LLB_ASSERT(a_clear_sets_time, aclk, aresetn, accept && (in_op == OP_CLEAR) |=> last_time_reg == $past(in_time), "clear beat did not store its time")
    `LLB_ASSERT(a_pass_keeps_time, aclk, aresetn, accept && (in_op == OP_REQUEST) && !is_limited_cat(in_cat) |=> $stable(last_time_reg), "pass-through beat moved the stored time")

endmodule

/* hdl/llb_decay.sv */
// Four-stage pipeline computing the request cost and the drain amount of each beat.
// Depends on llb_pkg; the drain is rate_cost * 6 * elapsed / 1000, split over stages.
module llb_decay (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  llb_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  llb_pkg::item_t             in_item,
    input  logic [llb_pkg::DIFF_W-1:0] in_diff,
    output logic                       out_valid,
    input  logic                       out_ready,
    output llb_pkg::item_t             out_item,
    output logic [llb_pkg::COST_W-1:0] out_cost,
    output logic [llb_pkg::LVL_W-1:0]  out_decay,
    output logic                       out_sat
);
    import llb_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    item_t             item1_reg, item2_reg, item3_reg, item4_reg;
    logic [COST_W-1:0] cost1_reg, cost2_reg, cost3_reg, cost4_reg;
    logic [PLO_W-1:0]  plo1_reg;
    logic [PHI_W-1:0]  phi1_reg;
    logic              sat2_reg, sat3_reg, sat4_reg;
    logic [Y_W-1:0]    y2_reg, y3_reg;
    logic [Q_W-1:0]    q3_reg;
    logic [LVL_W-1:0]  decay4_reg;

    logic [LVL_W-1:0]       base;
    logic [COST_PROD_W-1:0] cost_prod;
    logic [PROD_W-1:0]      prod;
    logic [QP_W-1:0]        qprod;
    logic [Y_W-1:0]         rem;
    logic [LVL_W-1:0]       decay_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        base      = (in_item.cat == CAT_TWO) ? cfg.cost_two : cfg.cost_one;
        cost_prod = COST_PROD_W'(base) * COST_PROD_W'(cfg.rate_cost);
        prod      = (PROD_W'(phi1_reg) << DLO_W) + PROD_W'(plo1_reg);
        qprod     = QP_W'(y2_reg) * QP_W'(RECIP_125);
        rem       = y3_reg - (Y_W'(q3_reg) * DIV_125);
        decay_next = (rem >= DIV_125) ? LVL_W'(q3_reg + 1'b1) : LVL_W'(q3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            item1_reg <= in_item;
            cost1_reg <= cost_prod[COST_PROD_W-1:16];
            plo1_reg  <= PLO_W'(cfg.rate_cost_x6) * PLO_W'(in_diff[DLO_W-1:0]);
            phi1_reg  <= PHI_W'(cfg.rate_cost_x6) * PHI_W'(in_diff[DIFF_W-1:DLO_W]);
        end
        if (rdy2) begin
            item2_reg <= item1_reg;
            cost2_reg <= cost1_reg;
            sat2_reg  <= (prod >= SAT_PRODUCT);
            y2_reg    <= prod[Y_W+Y_SHIFT-1:Y_SHIFT];
        end
        if (rdy3) begin
            item3_reg <= item2_reg;
            cost3_reg <= cost2_reg;
            sat3_reg  <= sat2_reg;
            y3_reg    <= y2_reg;
            q3_reg    <= qprod[QP_W-1:RECIP_SHIFT];
        end
        if (rdy4) begin
            item4_reg  <= item3_reg;
            cost4_reg  <= cost3_reg;
            sat4_reg   <= sat3_reg;
            decay4_reg <= decay_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;
    assign out_cost  = cost4_reg;
    assign out_decay = decay4_reg;
    assign out_sat   = sat4_reg;

endmodule

/* hdl/llb_bucket.sv */
// Bucket state and result register: drains, admits or rejects, and charges the cost.
// Depends on llb_pkg and the assertion macros.
`include "category_leaky_bucket_limiter_defines.svh"

module llb_bucket (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [llb_pkg::LVL_W-1:0]  rate_limit,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  llb_pkg::item_t             in_item,
    input  logic [llb_pkg::COST_W-1:0] in_cost,
    input  logic [llb_pkg::LVL_W-1:0]  in_decay,
    input  logic                       in_sat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_admitted,
    output logic [llb_pkg::LVL_W-1:0]  out_level
);
    import llb_pkg::*;

    logic [LVL_W-1:0] bucket_reg [NUM_BUCKETS];
    logic [LVL_W-1:0] bucket_next [NUM_BUCKETS];
    logic [LVL_W-1:0] drained [NUM_BUCKETS];
    logic             valid_reg;
    logic             valid_next;
    logic             admitted_reg;
    logic             admitted_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             load;
    logic             idx;
    logic             limit_on;
    logic [SUM_W-1:0] sum;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign idx      = (in_item.cat == CAT_TWO);
    assign limit_on = (rate_limit != '0);

    always_comb begin
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            drained[i] = (in_sat || (bucket_reg[i] <= in_decay)) ? '0
                                                                 : bucket_reg[i] - in_decay;
        end
        sum           = SUM_W'(drained[idx]) + SUM_W'(in_cost);
        bucket_next   = bucket_reg;
        admitted_next = 1'b1;
        level_next    = '0;
        case (in_item.op)
            OP_CLEAR: begin
                bucket_next = '{default: '0};
            end
            OP_DRAIN: begin
                bucket_next = drained;
            end
            OP_REQUEST: begin
                bucket_next = drained;
                if (is_request(in_item)) begin
                    if (limit_on) begin
                        if (sum > SUM_W'(rate_limit)) begin
                            admitted_next = 1'b0;
                        end else begin
                            bucket_next[idx] = (sum > SUM_W'(LVL_MAX)) ? LVL_MAX
                                                                       : sum[LVL_W-1:0];
                        end
                    end
                    level_next = bucket_next[idx];
                end
            end
            default: begin
                bucket_next = bucket_reg;
            end
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            bucket_reg <= '{default: '0};
        end else begin
            valid_reg <= valid_next;
            if (load) begin
                bucket_reg <= bucket_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            admitted_reg <= admitted_next;
            level_reg    <= level_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_admitted = admitted_reg;
    assign out_level    = level_reg;

    `LLB_ASSERT(a_clear_empties, aclk, aresetn, load && (in_item.op == OP_CLEAR) |=> (bucket_reg[0] == '0) && (bucket_reg[1] == '0), "clear beat left a bucket nonempty")
    `LLB_ASSERT(a_reject_cause, aclk, aresetn, load && !admitted_next |-> limit_on && is_request(in_item), "rejection without an active limit")
    `LLB_ASSERT(a_charge_in_limit, aclk, aresetn, load && admitted_next && limit_on && is_request(in_item) |=> level_reg <= $past(rate_limit), "admitted level above the limit")

endmodule

/* hdl/category_leaky_bucket_limiter.sv */
// Top level of the per-category leaky-bucket admission limiter.
// Depends on llb_pkg, llb_cfg, llb_front, llb_decay, llb_bucket and the assertion macros.
//
// One beat in per clock cycle while the output is not stalled, one result
// beat out per input beat, in order. An accepted input beat passes through
// an input register, four stages that form the request cost and the drain
// amount (the drain product is split into two partial products, and the
// division by 1000 is a reciprocal multiply with one correction step), and
// the result register, in front of which the two bucket levels are updated
// together. Every stage holds its beat only while the stage after it is
// full and stalled, so bubbles close up under back-pressure. Register writes
// take effect on the next cycle and are meant for idle periods.
`include "category_leaky_bucket_limiter_defines.svh"

module category_leaky_bucket_limiter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // time_ms
    input  logic [3:0]                    s_tuser,   // operation, category
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // bucket_level
    output logic [0:0]                    m_tuser,   // admitted
    input  logic                          cfg_we,
    input  logic [llb_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [llb_pkg::LVL_W-1:0]     cfg_wdata
);
    import llb_pkg::*;

    cfg_t              cfg;
    logic              f_valid;
    logic              f_ready;
    item_t             f_item;
    logic [DIFF_W-1:0] f_diff;
    logic              d_valid;
    logic              d_ready;
    item_t             d_item;
    logic [COST_W-1:0] d_cost;
    logic [LVL_W-1:0]  d_decay;
    logic              d_sat;
    logic              admitted;
    logic [LVL_W-1:0]  level;

    llb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    llb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[1:0]),
        .in_time   (s_tdata),
        .in_cat    (s_tuser[3:2]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item),
        .out_diff  (f_diff)
    );

    llb_decay u_decay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .in_diff   (f_diff),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item),
        .out_cost  (d_cost),
        .out_decay (d_decay),
        .out_sat   (d_sat)
    );

    llb_bucket u_bucket (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rate_limit   (cfg.rate_limit),
        .in_valid     (d_valid),
        .in_ready     (d_ready),
        .in_item      (d_item),
        .in_cost      (d_cost),
        .in_decay     (d_decay),
        .in_sat       (d_sat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_admitted (admitted),
        .out_level    (level)
    );

    assign m_tdata = level;
    assign m_tuser = admitted;

    `LLB_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for category_leaky_bucket_limiter, with stream traffic and bursty stalls.
// Holds its own admission predictor and compares every result beat in order; needs llb_pkg and the limiter RTL.
module tb_top;
    import llb_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic [CAT_W-1:0] CAT_FREE_LO = 2'd0;
    localparam logic [CAT_W-1:0] CAT_FREE_HI = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        logic [CAT_W-1:0]  cat;
    } beat_t;

    typedef struct packed {
        logic             admitted;
        logic [LVL_W-1:0] level;
    } verdict_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [3:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [23:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [LVL_W-1:0]     cfg_wdata = '0;

    beat_t    pending_beats[$];
    verdict_t verdict_q[$];

    logic [LVL_W-1:0]  ceiling    = RATE_LIMIT_RST;
    logic [LVL_W-1:0]  cost_scale = RATE_COST_RST;
    logic [LVL_W-1:0]  charge_one = COST_CAT_RST;
    logic [LVL_W-1:0]  charge_two = COST_CAT_RST;
    logic [LVL_W-1:0]  fill [NUM_BUCKETS] = '{default: '0};
    logic [TIME_W-1:0] drain_stamp = '0;
    logic [TIME_W-1:0] t_cursor    = '0;

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int rx_count    = 0;
    int rx_period   = 1;
    int rx_on       = 1;

    category_leaky_bucket_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic void drain_buckets(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       decay;
        elapsed = now - drain_stamp;
        if (elapsed == '0)
            return;
        drain_stamp = now;
        if (elapsed[TIME_W-1])
            return;
        decay = (64'(cost_scale) * 64'd6 * 64'(elapsed)) / 64'd1000;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (64'(fill[i]) <= decay)
                fill[i] = '0;
            else
                fill[i] = fill[i] - decay[LVL_W-1:0];
        end
    endfunction

    function automatic verdict_t admit_beat(input beat_t b);
        verdict_t    v;
        logic [63:0] charge;
        logic [63:0] total;
        int          idx;
        v.admitted = 1'b1;
        v.level    = '0;
        if (b.op == OP_CLEAR) begin
            fill[0]     = '0;
            fill[1]     = '0;
            drain_stamp = b.stamp;
        end else if (b.op == OP_DRAIN) begin
            drain_buckets(b.stamp);
        end else if (b.op == OP_REQUEST && (b.cat == CAT_ONE || b.cat == CAT_TWO)) begin
            idx = (b.cat == CAT_ONE) ? 0 : 1;
            drain_buckets(b.stamp);
            if (ceiling != '0) begin
                charge = (64'((b.cat == CAT_ONE) ? charge_one : charge_two)
                          * 64'(cost_scale)) >> 16;
                total  = 64'(fill[idx]) + charge;
                if (total > 64'(ceiling))
                    v.admitted = 1'b0;
                else
                    fill[idx] = (total > 64'(LVL_MAX)) ? LVL_MAX : total[LVL_W-1:0];
            end
            v.level = fill[idx];
        end
        return v;
    endfunction

    function automatic logic [CAT_W-1:0] CAT_CAT_PICK();
        return CAT_W'($urandom_range(0, 3));
    endfunction

    function automatic beat_t random_beat(input int step_max);
        beat_t b;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            t_cursor += $urandom_range(1, step_max);
        else if (pick < 53)
            t_cursor += $urandom_range(21, 400);
        else if (pick < 63)
            t_cursor -= $urandom_range(1, 1000);
        else if (pick < 71)
            t_cursor += $urandom_range(1000, 32'h7FFF_FFFF);
        else if (pick < 77)
            t_cursor += 32'h8000_0000 + $urandom_range(0, 1000);
        else if (pick < 85)
            t_cursor = $urandom();
        b.stamp = t_cursor;
        b.cat   = CAT_CAT_PICK();
        pick    = $urandom_range(0, 99);
        if (pick < 75) begin
            b.op = OP_REQUEST;
            if ($urandom_range(0, 99) < 85)
                b.cat = ($urandom_range(0, 1) != 0) ? CAT_TWO : CAT_ONE;
            else
                b.cat = ($urandom_range(0, 1) != 0) ? CAT_FREE_HI : CAT_FREE_LO;
        end else if (pick < 94) begin
            b.op = OP_DRAIN;
        end else if (pick < 97) begin
            b.op = OP_CLEAR;
        end else begin
            b.op = OP_UNUSED;
        end
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_RATE_LIMIT:   ceiling    = value;
            CFG_RATE_COST:    cost_scale = value;
            CFG_COST_CAT_ONE: charge_one = value;
            CFG_COST_CAT_TWO: charge_two = value;
            default: ;
        endcase
    endtask

    task automatic write_limits(input logic [LVL_W-1:0] limit, scale, one, two);
        write_reg(CFG_RATE_LIMIT, limit);
        write_reg(CFG_RATE_COST, scale);
        write_reg(CFG_COST_CAT_ONE, one);
        write_reg(CFG_COST_CAT_TWO, two);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(input int count, input int step_max);
        repeat (count) pending_beats.push_back(random_beat(step_max));
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (12) @(negedge aclk);
    endtask

    task automatic flag_error(input string what, input verdict_t want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected admitted=%0d level=%06h, got admitted=%0d level=%06h",
                     $realtime, what, want.admitted, want.level, m_tuser[0], m_tdata);
    endtask

    always @(posedge aclk) begin : driver
        beat_t next_beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(admit_beat(beat_t'{s_tuser[OP_W-1:0], s_tdata,
                                                       s_tuser[3:2]}));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    next_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.stamp;
                    s_tuser  <= {next_beat.cat, next_beat.op};
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(7, 20);
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        verdict_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_error("result beat with nothing expected", '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tuser[0] !== want.admitted)
                        flag_error("admitted mismatch", want);
                    if (m_tdata !== want.level)
                        flag_error("bucket_level mismatch", want);
                end
            end
            if (rx_count == 0) begin
                rx_period = $urandom_range(1, 8);
                rx_on = ($urandom_range(0, 2) == 0) ? rx_period : $urandom_range(1, rx_period);
            end
            m_tready <= (rx_count % rx_period) < rx_on;
            rx_count = (rx_count + 1) % 64;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("category_leaky_bucket_limiter verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd0, CAT_ONE});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd0, CAT_TWO});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd0, CAT_FREE_LO});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd0, CAT_FREE_HI});
        pending_beats.push_back(beat_t'{OP_UNUSED, 32'hFFFF_FFFF, CAT_ONE});
        pending_beats.push_back(beat_t'{OP_DRAIN, 32'd5, CAT_TWO});
        repeat (10) pending_beats.push_back(beat_t'{OP_REQUEST, 32'd5, CAT_ONE});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd2, CAT_TWO});
        pending_beats.push_back(beat_t'{OP_DRAIN, 32'd1000, CAT_FREE_LO});
        pending_beats.push_back(beat_t'{OP_CLEAR, 32'hFFFF_FFF0, CAT_FREE_HI});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'hFFFF_FFFF, CAT_ONE});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd5, CAT_ONE});
        pending_beats.push_back(beat_t'{OP_DRAIN, 32'h8000_0004, CAT_FREE_LO});
        pending_beats.push_back(beat_t'{OP_REQUEST, 32'd4, CAT_TWO});
        pending_beats.push_back(beat_t'{OP_CLEAR, 32'd0, CAT_ONE});
        t_cursor = '0;
        run_random(150, 20);
        wait_drained();

        write_limits(24'd65536, 24'd65536, 24'd16384, 24'd65536);
        t_cursor += 5000;
        pending_beats.push_back(beat_t'{OP_DRAIN, t_cursor, CAT_FREE_LO});
        repeat (5) pending_beats.push_back(beat_t'{OP_REQUEST, t_cursor, CAT_ONE});
        repeat (2) pending_beats.push_back(beat_t'{OP_REQUEST, t_cursor, CAT_TWO});
        run_random(150, 4);
        wait_drained();

        write_limits(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX);
        run_random(100, 20);
        wait_drained();

        write_limits('0, 24'($urandom_range(1, 24'h04_0000)),
                     24'($urandom_range(1, 24'h02_0000)), 24'($urandom_range(1, 24'h02_0000)));
        run_random(150, 10);
        wait_drained();

        write_limits(24'($urandom_range(1, 24'hFF_FFFF)), '0,
                     24'($urandom_range(0, 24'hFF_FFFF)), 24'($urandom_range(0, 24'hFF_FFFF)));
        run_random(150, 10);
        wait_drained();

        write_limits(24'd1, LVL_MAX, '0, '0);
        run_random(100, 20);
        wait_drained();

        repeat (3) begin
            write_limits(24'($urandom_range(1, 24'hFF_FFFF)),
                         24'($urandom_range(24'h00_4000, 24'h04_0000)),
                         24'($urandom_range(0, 24'h02_0000)),
                         24'($urandom_range(0, 24'h02_0000)));
            run_random(180, $urandom_range(1, 30));
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("category_leaky_bucket_limiter verification clean");
        else
            $display("category_leaky_bucket_limiter verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/llb_pkg.sv
hdl/llb_cfg.sv
hdl/llb_front.sv
hdl/llb_decay.sv
hdl/llb_bucket.sv
hdl/category_leaky_bucket_limiter.sv
tb/tb_top.sv
